>>> sv/color_sensor_window_counter_macros.svh
// ----------------------------------------------------------------------------
// Color sensor window counter: assertion macros
// Shared concurrent assertion forms, all clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef COLOR_SENSOR_WINDOW_COUNTER_MACROS_SVH
`define COLOR_SENSOR_WINDOW_COUNTER_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define CSW_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define CSW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/csw_pkg.sv
// ----------------------------------------------------------------------------
// Color sensor window counter package
// Widths, phase and filter codes, and the request and result structures.
// ----------------------------------------------------------------------------
`default_nettype none

package csw_pkg;

  // Edge counter width per window and window timer width.
  localparam int COUNT_WIDTH = 24;
  localparam int DWELL_WIDTH = 32;
  // Width of the dwell configuration register.
  localparam int CFG_WIDTH   = 32;
  // Number of counting windows.
  localparam int NUM_WIN     = 5;
  // Width wide enough to compare the register against the timer range.
  localparam int LEN_W       = (DWELL_WIDTH > CFG_WIDTH) ? DWELL_WIDTH : CFG_WIDTH;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [DWELL_WIDTH-1:0] DWELL_MAX = '1;
  localparam logic [CFG_WIDTH-1:0]   DWELL_RESET = CFG_WIDTH'(1000);

  // Measurement sequence phases.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WHITE_HEAD,
    PH_RED,
    PH_GREEN,
    PH_BLUE,
    PH_WHITE_TAIL,
    PH_DONE
  } phase_t;

  // Filter select pin codes {s2,s3}.
  typedef enum logic [1:0] {
    FIL_RED   = 2'd0,
    FIL_BLUE  = 2'd1,
    FIL_WHITE = 2'd2,
    FIL_GREEN = 2'd3
  } filt_t;

  // One input request.
  typedef struct packed {
    logic sensor_level;
    logic start_req;
    logic stop;
  } sample_t;

  // One result: pin state, status and window counts (index 0 is white head).
  typedef struct packed {
    filt_t                                  filter_select;
    logic                                   scale_on;
    logic                                   led_enable_n;
    logic                                   busy;
    logic                                   done;
    logic [NUM_WIN-1:0][COUNT_WIDTH-1:0]    counts;
  } result_t;

  // Effective window length: zero reads as one, capped at the timer range.
  function automatic logic [DWELL_WIDTH-1:0] win_length(input logic [CFG_WIDTH-1:0] d);
    logic [LEN_W-1:0] dx;
    logic [LEN_W-1:0] cap;
    dx  = LEN_W'(d);
    cap = LEN_W'(DWELL_MAX);
    if (dx == '0) begin
      dx = LEN_W'(1);
    end
    if (dx > cap) begin
      dx = cap;
    end
    return dx[DWELL_WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

>>> sv/color_sensor_window_counter.sv
// ----------------------------------------------------------------------------
// Color sensor window counter
// Top level: input register, sequencer and result register.
// ----------------------------------------------------------------------------
// Each request is one sample tick and yields exactly one result. A request
// is taken every clock cycle while results are being consumed; it goes through
// the input register, then the sequencer, into the result register. Throughput
// is set only by out_ready back-pressure, and a finished result can wait in the
// result register while the next request is already held in the input
// register. The user writes dwell_ticks through cfg_wr_en and cfg_wr_data
// only while no requests are in flight; the block does not enforce this.
`default_nettype none

`include "color_sensor_window_counter_macros.svh"

module color_sensor_window_counter
  import csw_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_WIDTH-1:0]   cfg_wr_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   in_sensor_level,
  input  wire logic                   in_start_req,
  input  wire logic                   in_stop,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [1:0]                  out_filter_select,
  output logic                        out_scale_on,
  output logic                        out_led_enable_n,
  output logic                        out_busy_res,
  output logic                        out_done_res,
  output logic [COUNT_WIDTH-1:0]      out_white_head_count,
  output logic [COUNT_WIDTH-1:0]      out_red_count,
  output logic [COUNT_WIDTH-1:0]      out_green_count,
  output logic [COUNT_WIDTH-1:0]      out_blue_count,
  output logic [COUNT_WIDTH-1:0]      out_white_tail_count
);

  sample_t in_smp;
  sample_t smp;
  logic    smp_valid;
  logic    advance;
  logic    step_en;
  result_t res;
  result_t out_res_r;
  logic    out_valid_r;
  logic    out_valid_nxt;

  assign in_smp.sensor_level = in_sensor_level;
  assign in_smp.start_req    = in_start_req;
  assign in_smp.stop         = in_stop;

  // The result register frees up when empty or being taken.
  assign advance = !out_valid_r || out_ready;
  assign step_en = smp_valid && advance;

  csw_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_smp    (in_smp),
    .advance   (advance),
    .smp_valid (smp_valid),
    .smp       (smp)
  );

  csw_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step_en     (step_en),
    .smp         (smp),
    .res         (res)
  );

  // Result register.
  assign out_valid_nxt = advance ? smp_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_res_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_filter_select    = out_res_r.filter_select;
  assign out_scale_on         = out_res_r.scale_on;
  assign out_led_enable_n     = out_res_r.led_enable_n;
  assign out_busy_res         = out_res_r.busy;
  assign out_done_res         = out_res_r.done;
  assign out_white_head_count = out_res_r.counts[0];
  assign out_red_count        = out_res_r.counts[1];
  assign out_green_count      = out_res_r.counts[2];
  assign out_blue_count       = out_res_r.counts[3];
  assign out_white_tail_count = out_res_r.counts[4];

  // A sequence completes out of the done phase after the white tail window, so the filter is still white.
  `CSW_ASSERT_SAME(a_done_white, out_valid_r && out_done_res, out_filter_select == FIL_WHITE, "done off white")
  // The sensor is powered exactly while a sequence runs.
  `CSW_ASSERT_SAME(a_scale_busy, out_valid_r, out_scale_on == out_busy_res, "scale vs busy")
  // The LED is lit exactly while the sensor is powered.
  `CSW_ASSERT_SAME(a_led_scale, out_valid_r, out_led_enable_n != out_scale_on, "LED vs scale")
  // An accepted request always lands in the input register.
  `CSW_ASSERT_NEXT(a_in_lands, in_valid && in_ready, smp_valid, "accepted request lost")

endmodule

`default_nettype wire

>>> sv/csw_in_reg.sv
// ----------------------------------------------------------------------------
// Color sensor window counter: input register
// Captures one request per cycle while the sequencer stage moves on, and hands it to that stage.
// ----------------------------------------------------------------------------
`default_nettype none

module csw_in_reg
  import csw_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire sample_t in_smp,
  input  wire logic    advance,
  output logic         smp_valid,
  output sample_t      smp
);

  logic    valid_r;
  logic    valid_nxt;
  sample_t smp_r;

  // The stage frees up whenever it is empty or its request moves on.
  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload loads on every accepted request.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      smp_r <= in_smp;
    end
  end

  assign smp_valid = valid_r;
  assign smp       = smp_r;

endmodule

`default_nettype wire

>>> sv/csw_seq.sv
// ----------------------------------------------------------------------------
// Color sensor window counter: sequencer
// Window timer, phase state machine, pin state and saturating edge counters.
// ----------------------------------------------------------------------------
`default_nettype none

module csw_seq
  import csw_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_WIDTH-1:0] cfg_wr_data,
  input  wire logic                 step_en,
  input  wire sample_t              smp,
  output result_t                   res
);

  phase_t                              phase_r;
  phase_t                              phase_nxt;
  logic [DWELL_WIDTH-1:0]              win_len_r;
  logic [DWELL_WIDTH-1:0]              cnt_r;
  logic [DWELL_WIDTH-1:0]              cnt_nxt;
  logic [DWELL_WIDTH-1:0]              cnt_inc;
  logic                                prev_r;
  filt_t                               filter_r;
  filt_t                               filter_nxt;
  logic                                scale_r;
  logic                                scale_nxt;
  logic                                led_n_r;
  logic                                led_n_nxt;
  logic                                done_w;
  logic                                close_w;
  logic                                falling;
  logic [NUM_WIN-1:0][COUNT_WIDTH-1:0] counts_r;
  logic [NUM_WIN-1:0][COUNT_WIDTH-1:0] counts_nxt;

  // The window length is settled when the register is written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r <= win_length(DWELL_RESET);
    end else if (cfg_wr_en) begin
      win_len_r <= win_length(cfg_wr_data);
    end
  end

  // Window timer: a window closes on its win_len-th tick.
  assign cnt_inc = cnt_r + DWELL_WIDTH'(1);
  assign close_w = (phase_r != PH_IDLE) && (cnt_inc >= win_len_r);
  assign falling = prev_r && !smp.sensor_level;

  // Next phase: timer advance first, then stop or start.
  always_comb begin
    phase_nxt = phase_r;
    if (close_w) begin
      unique case (phase_r)
        PH_WHITE_HEAD: phase_nxt = PH_RED;
        PH_RED:        phase_nxt = PH_GREEN;
        PH_GREEN:      phase_nxt = PH_BLUE;
        PH_BLUE:       phase_nxt = PH_WHITE_TAIL;
        PH_WHITE_TAIL: phase_nxt = PH_DONE;
        default:       phase_nxt = PH_IDLE;
      endcase
    end
    if (smp.stop) begin
      phase_nxt = PH_IDLE;
    end else if (smp.start_req) begin
      phase_nxt = PH_WHITE_HEAD;
    end
  end

  // Timer, pins and done pulse for the same order of events.
  always_comb begin
    cnt_nxt    = cnt_r;
    filter_nxt = filter_r;
    scale_nxt  = scale_r;
    led_n_nxt  = led_n_r;
    done_w     = 1'b0;
    if (phase_r != PH_IDLE) begin
      cnt_nxt = close_w ? '0 : cnt_inc;
    end
    if (close_w) begin
      unique case (phase_r)
        PH_WHITE_HEAD: filter_nxt = FIL_RED;
        PH_RED:        filter_nxt = FIL_GREEN;
        PH_GREEN:      filter_nxt = FIL_BLUE;
        PH_BLUE:       filter_nxt = FIL_WHITE;
        PH_DONE: begin
          scale_nxt = 1'b0;
          led_n_nxt = 1'b1;
          done_w    = 1'b1;
        end
        default: ;
      endcase
    end
    // Stop keeps the filter selection and suppresses the done pulse.
    if (smp.stop) begin
      scale_nxt = 1'b0;
      led_n_nxt = 1'b1;
      cnt_nxt   = '0;
      done_w    = 1'b0;
    end else if (smp.start_req) begin
      scale_nxt  = 1'b1;
      led_n_nxt  = 1'b0;
      filter_nxt = FIL_WHITE;
      cnt_nxt    = '0;
    end
  end

  // Edge counters: one lane per window, counting only in its own phase.
  // Counting is enabled exactly while a window phase is active, so the
  // phase alone gates the count. A start clears after the edge is counted.
  always_comb begin
    counts_nxt = counts_r;
    for (int k = 0; k < NUM_WIN; k++) begin
      if (falling && (phase_r == phase_t'(3'(k + 1))) && (counts_r[k] != COUNT_MAX)) begin
        counts_nxt[k] = counts_r[k] + COUNT_WIDTH'(1);
      end
      if (!smp.stop && smp.start_req) begin
        counts_nxt[k] = '0;
      end
    end
  end

  // State registers advance once per request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      cnt_r    <= '0;
      prev_r   <= 1'b0;
      filter_r <= FIL_RED;
      scale_r  <= 1'b0;
      led_n_r  <= 1'b1;
      counts_r <= '0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      prev_r   <= smp.sensor_level;
      filter_r <= filter_nxt;
      scale_r  <= scale_nxt;
      led_n_r  <= led_n_nxt;
      counts_r <= counts_nxt;
    end
  end

  // Result shows the state after this request.
  always_comb begin
    res.filter_select = filter_nxt;
    res.scale_on      = scale_nxt;
    res.led_enable_n  = led_n_nxt;
    res.busy          = (phase_nxt != PH_IDLE);
    res.done          = done_w;
    res.counts        = counts_nxt;
  end

endmodule

`default_nettype wire

>>> test/tb_color_sensor_window_counter.sv
// ----------------------------------------------------------------------------
// Color sensor window counter testbench
// Sends sample-tick requests with start and stop mixed in, and keeps its own
// model of the window sequencer. Every result is checked field by field. The
// directed table comes first. Random measurement sequences follow, run under
// several window lengths, with bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_color_sensor_window_counter;
  import csw_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_ITEMS = 140;
  localparam logic [CFG_WIDTH-1:0] PHASE_DWELL [8] = '{
    32'd1, 32'd2, 32'd0, 32'd3, 32'hFFFF_FFFF, 32'd5, DWELL_RESET, 32'd4
  };

  // Ways a random measurement sequence can end.
  typedef enum int {
    END_QUIET,
    END_RESTART_AT_DONE,
    END_STOP_AT_DONE,
    END_STOP_EARLY,
    END_RESTART_EARLY
  } seq_end_e;

  // Receiver back-pressure patterns.
  typedef enum int {RX_OPEN, RX_SPARSE, RX_PERIODIC, RX_COIN} rx_pattern_e;

  // One row of the directed table.
  typedef struct {
    logic [CFG_WIDTH-1:0] dwell;
    logic                 level;
    logic                 start_req;
    logic                 stop;
    bit                   pinned;
    result_t              pinned_res;
  } directed_tick_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_WIDTH-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_sensor_level = 1'b0;
  logic in_start_req = 1'b0;
  logic in_stop = 1'b0;
  logic out_valid;
  logic out_ready = 1'b1;
  logic [1:0] out_filter_select;
  logic out_scale_on;
  logic out_led_enable_n;
  logic out_busy_res;
  logic out_done_res;
  logic [COUNT_WIDTH-1:0] out_white_head_count;
  logic [COUNT_WIDTH-1:0] out_red_count;
  logic [COUNT_WIDTH-1:0] out_green_count;
  logic [COUNT_WIDTH-1:0] out_blue_count;
  logic [COUNT_WIDTH-1:0] out_white_tail_count;

  // Sequencer model state.
  logic [CFG_WIDTH-1:0]   dwell_reg;
  phase_t                 seq_phase;
  logic [DWELL_WIDTH-1:0] window_timer;
  logic                   counting_on;
  logic                   last_level;
  logic [COUNT_WIDTH-1:0] edge_tally [NUM_WIN];
  filt_t                  filt_pin;
  logic                   scale_pin;
  logic                   led_n_pin;

  result_t expected_pins [$];
  directed_tick_t plan [$];
  int unsigned failures = 0;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  int unsigned cycle_count = 0;
  rx_pattern_e rx_pattern = RX_OPEN;
  int unsigned rx_left = 0;
  int unsigned rx_tick = 0;

  color_sensor_window_counter i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_sensor_level      (in_sensor_level),
    .in_start_req         (in_start_req),
    .in_stop              (in_stop),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_filter_select    (out_filter_select),
    .out_scale_on         (out_scale_on),
    .out_led_enable_n     (out_led_enable_n),
    .out_busy_res         (out_busy_res),
    .out_done_res         (out_done_res),
    .out_white_head_count (out_white_head_count),
    .out_red_count        (out_red_count),
    .out_green_count      (out_green_count),
    .out_blue_count       (out_blue_count),
    .out_white_tail_count (out_white_tail_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Sensor power-down: pins off, timer cleared, sequence back to idle.
  function automatic void power_down_pins();
    scale_pin = 1'b0;
    led_n_pin = 1'b1;
    counting_on = 1'b0;
    seq_phase = PH_IDLE;
    window_timer = '0;
  endfunction

  // Advance the sequencer model by one tick and return the pin and count state.
  function automatic result_t advance_sequencer(logic lvl, logic st, logic sp);
    result_t r;
    logic fell;
    logic pulse;
    logic [DWELL_WIDTH-1:0] span;
    int w;
    fell = last_level && !lvl;
    last_level = lvl;
    pulse = 1'b0;

    // Count the falling edge in the open color window, saturating.
    if (fell && counting_on && seq_phase != PH_IDLE && seq_phase != PH_DONE) begin
      w = int'(seq_phase) - int'(PH_WHITE_HEAD);
      if (edge_tally[w] != COUNT_MAX) begin
        edge_tally[w] = edge_tally[w] + 1'b1;
      end
    end

    // Zero length reads as one tick; longer than the timer is capped.
    if (64'(dwell_reg) > 64'(DWELL_MAX)) begin
      span = DWELL_MAX;
    end else begin
      span = DWELL_WIDTH'(dwell_reg);
    end
    if (span == '0) begin
      span = DWELL_WIDTH'(1);
    end

    // Window timer and phase step.
    if (seq_phase != PH_IDLE) begin
      window_timer = window_timer + 1'b1;
      if (window_timer >= span) begin
        window_timer = '0;
        case (seq_phase)
          PH_WHITE_HEAD: begin
            filt_pin = FIL_RED;
            seq_phase = PH_RED;
          end
          PH_RED: begin
            filt_pin = FIL_GREEN;
            seq_phase = PH_GREEN;
          end
          PH_GREEN: begin
            filt_pin = FIL_BLUE;
            seq_phase = PH_BLUE;
          end
          PH_BLUE: begin
            filt_pin = FIL_WHITE;
            seq_phase = PH_WHITE_TAIL;
          end
          PH_WHITE_TAIL: begin
            seq_phase = PH_DONE;
          end
          default: begin
            power_down_pins();
            pulse = 1'b1;
          end
        endcase
      end
    end

    // Stop wins over start; start clears the counts and opens the head window.
    if (sp) begin
      power_down_pins();
      pulse = 1'b0;
    end else if (st) begin
      foreach (edge_tally[k]) edge_tally[k] = '0;
      scale_pin = 1'b1;
      filt_pin = FIL_WHITE;
      led_n_pin = 1'b0;
      counting_on = 1'b1;
      seq_phase = PH_WHITE_HEAD;
      window_timer = '0;
    end

    r = '0;
    r.filter_select = filt_pin;
    r.scale_on = scale_pin;
    r.led_enable_n = led_n_pin;
    r.busy = (seq_phase != PH_IDLE);
    r.done = pulse;
    for (int k = 0; k < NUM_WIN; k++) begin
      r.counts[k] = edge_tally[k];
    end
    return r;
  endfunction

  // Append a directed row; a pinned row carries its expected pins, counts zero.
  function automatic void add_row(logic [CFG_WIDTH-1:0] dw, logic lv, logic st, logic sp,
                                  bit pinned = 1'b0, filt_t f = FIL_RED,
                                  logic sc = 1'b0, logic led = 1'b1, logic busy = 1'b0);
    directed_tick_t row;
    row.dwell = dw;
    row.level = lv;
    row.start_req = st;
    row.stop = sp;
    row.pinned = pinned;
    row.pinned_res = '0;
    row.pinned_res.filter_select = f;
    row.pinned_res.scale_on = sc;
    row.pinned_res.led_enable_n = led;
    row.pinned_res.busy = busy;
    plan.push_back(row);
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      failures++;
    end
  endfunction

  // Send one sample request in bursts with random gaps, then predict its result.
  task automatic send_sample(input logic lvl, input logic st, input logic sp,
                             input bit pinned = 1'b0, input result_t pinned_res = '0);
    result_t predicted;
    int unsigned gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(40, 160);
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(1, 6);
      end
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_sensor_level <= lvl;
    in_start_req <= st;
    in_stop <= sp;
    do @(posedge clk); while (in_ready !== 1'b1);
    predicted = advance_sequencer(lvl, st, sp);
    expected_pins.push_back(pinned ? pinned_res : predicted);
    items_sent++;
  endtask

  // Hold requests back until every expected result has come out.
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_pins.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic settle_and_configure(input logic [CFG_WIDTH-1:0] value);
    wait_for_drain();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    dwell_reg = value;
  endtask

  // One well-formed measurement: start, random sensor levels, then an ending.
  task automatic run_measurement(input longint unsigned span);
    longint unsigned full;
    longint unsigned cut;
    seq_end_e how;
    full = 6 * span;
    if (full > 64) begin
      how = ($urandom_range(0, 1) == 0) ? END_STOP_EARLY : END_RESTART_EARLY;
    end else begin
      how = seq_end_e'($urandom_range(0, 4));
    end
    send_sample(1'($urandom_range(0, 1)), 1'b1, 1'b0);
    case (how)
      END_STOP_EARLY, END_RESTART_EARLY: begin
        cut = $urandom_range(1, (full - 1 > 60) ? 60 : int'(full - 1));
        for (longint unsigned k = 1; k < cut; k++) begin
          send_sample(1'($urandom_range(0, 1)), 1'b0, 1'b0);
        end
        send_sample(1'($urandom_range(0, 1)), how == END_RESTART_EARLY,
                    how == END_STOP_EARLY);
      end
      default: begin
        for (longint unsigned k = 1; k < full; k++) begin
          send_sample(1'($urandom_range(0, 1)), 1'b0, 1'b0);
        end
        // The last tick is the completion tick.
        send_sample(1'($urandom_range(0, 1)), how == END_RESTART_AT_DONE,
                    how == END_STOP_AT_DONE);
        repeat ($urandom_range(0, 3)) send_sample(1'($urandom_range(0, 1)), 1'b0, 1'b0);
      end
    endcase
  endtask

  task automatic run_random_phase(input logic [CFG_WIDTH-1:0] dwell, input int unsigned n);
    int unsigned target;
    longint unsigned span;
    settle_and_configure(dwell);
    span = (dwell == '0) ? 1 : longint'(dwell);
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(0, 4) != 0) begin
        run_measurement(span);
      end else begin
        // Loose requests with stray starts and stops.
        repeat ($urandom_range(1, 5)) begin
          send_sample(1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0,
                      $urandom_range(0, 7) == 0);
        end
      end
    end
  endtask

  // Receiver: back-pressure follows a randomly chosen pattern, redrawn when its run ends.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_pattern = rx_pattern_e'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 96);
    end
    rx_left--;
    rx_tick++;
    case (rx_pattern)
      RX_OPEN:     out_ready <= 1'b1;
      RX_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
      RX_PERIODIC: out_ready <= (rx_tick % 5 < 3);
      default:     out_ready <= 1'($urandom_range(0, 1));
    endcase
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (expected_pins.size() == 0) begin
        $error("result with no request outstanding");
        failures++;
      end else begin
        want = expected_pins.pop_front();
        check_field("filter_select", 32'(want.filter_select), 32'(out_filter_select));
        check_field("scale_on", 32'(want.scale_on), 32'(out_scale_on));
        check_field("led_enable_n", 32'(want.led_enable_n), 32'(out_led_enable_n));
        check_field("busy_res", 32'(want.busy), 32'(out_busy_res));
        check_field("done_res", 32'(want.done), 32'(out_done_res));
        check_field("white_head_count", 32'(want.counts[0]),
                    32'(out_white_head_count));
        check_field("red_count", 32'(want.counts[1]), 32'(out_red_count));
        check_field("green_count", 32'(want.counts[2]), 32'(out_green_count));
        check_field("blue_count", 32'(want.counts[3]), 32'(out_blue_count));
        check_field("white_tail_count", 32'(want.counts[4]),
                    32'(out_white_tail_count));
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_color_sensor_window_counter: done, errors");
      $finish;
    end
  end

  initial begin
    // Model state after reset.
    dwell_reg = DWELL_RESET;
    last_level = 1'b0;
    foreach (edge_tally[k]) edge_tally[k] = '0;
    filt_pin = FIL_RED;
    power_down_pins();

    // Reset value of the window length: idle ticks, stop while idle, start,
    // restart with an edge on the start tick, then stop.
    add_row(DWELL_RESET, 1'b0, 1'b0, 1'b0, 1'b1, FIL_RED, 1'b0, 1'b1, 1'b0);
    add_row(DWELL_RESET, 1'b1, 1'b0, 1'b1, 1'b1, FIL_RED, 1'b0, 1'b1, 1'b0);
    add_row(DWELL_RESET, 1'b0, 1'b0, 1'b0, 1'b1, FIL_RED, 1'b0, 1'b1, 1'b0);
    add_row(DWELL_RESET, 1'b1, 1'b1, 1'b0, 1'b1, FIL_WHITE, 1'b1, 1'b0, 1'b1);
    add_row(DWELL_RESET, 1'b0, 1'b0, 1'b0);
    add_row(DWELL_RESET, 1'b1, 1'b0, 1'b0);
    add_row(DWELL_RESET, 1'b0, 1'b1, 1'b0, 1'b1, FIL_WHITE, 1'b1, 1'b0, 1'b1);
    add_row(DWELL_RESET, 1'b1, 1'b0, 1'b1, 1'b1, FIL_WHITE, 1'b0, 1'b1, 1'b0);
    // Zero window length acts as one tick: a full sequence, a restart on
    // the completion tick, a second sequence stopped on its completion tick.
    add_row(32'd0, 1'b1, 1'b1, 1'b0, 1'b1, FIL_WHITE, 1'b1, 1'b0, 1'b1);
    add_row(32'd0, 1'b0, 1'b0, 1'b0);
    add_row(32'd0, 1'b1, 1'b0, 1'b0);
    add_row(32'd0, 1'b0, 1'b0, 1'b0);
    add_row(32'd0, 1'b1, 1'b0, 1'b0);
    add_row(32'd0, 1'b0, 1'b0, 1'b0);
    add_row(32'd0, 1'b1, 1'b1, 1'b0);
    add_row(32'd0, 1'b0, 1'b0, 1'b0);
    add_row(32'd0, 1'b1, 1'b0, 1'b0);
    add_row(32'd0, 1'b0, 1'b0, 1'b0);
    add_row(32'd0, 1'b1, 1'b0, 1'b0);
    add_row(32'd0, 1'b0, 1'b0, 1'b0);
    add_row(32'd0, 1'b1, 1'b0, 1'b1);
    add_row(32'd0, 1'b0, 1'b0, 1'b1);
    // Longest window length.
    add_row(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b1, FIL_WHITE, 1'b1, 1'b0, 1'b1);
    add_row(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
    add_row(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table.
    foreach (plan[i]) begin
      if (plan[i].dwell != dwell_reg) begin
        settle_and_configure(plan[i].dwell);
      end
      send_sample(plan[i].level, plan[i].start_req, plan[i].stop,
                  plan[i].pinned, plan[i].pinned_res);
    end

    // Random measurement sequences under several window lengths.
    foreach (PHASE_DWELL[p]) begin
      run_random_phase(PHASE_DWELL[p], PHASE_ITEMS);
    end
    run_random_phase($urandom_range(1, 6), PHASE_ITEMS);

    wait_for_drain();
    repeat (10) @(posedge clk);
    if (failures == 0 && expected_pins.size() == 0) begin
      $display("tb_color_sensor_window_counter: done, clean");
    end else begin
      $display("tb_color_sensor_window_counter: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
